// ===== hdl/ipap_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the IPv4 address pool allocator.
// No dependencies; imported by the controller, the datapath and the top level.
package ipap_pkg;

   // Pool geometry
   localparam int POOL_DEPTH = 256;
   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int COUNT_W    = $clog2(POOL_DEPTH + 1);
   localparam int SUM_W      = COUNT_W + 1;
   localparam int ADDR_W     = 32;

   // Item kinds carried in the request tuser
   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_ALLOC   = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_ALLOC = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ALLOC_WR,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       capture;        // latch the request beat
      logic       ring_load;      // write address at free tail, free count up
      logic       alloc_commit;   // move free head into allocated tail
      logic       scan_start;     // read allocated entry 0, index to 0
      logic       scan_step;      // advance scan index
      logic       shift_step;     // copy entry index+1 down to index
      logic       release_commit; // drop one allocated, push address on free head
      logic       clear;          // empty both lists
      logic       set_status;     // overwrite result status
      status_type status;
      logic       load_out;       // load the result register
   } ipap_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      mode_type mode;
      logic     full;        // free + allocated at capacity
      logic     free_empty;
      logic     alloc_empty;
      logic     match;       // allocated entry under scan equals request address
      logic     scan_last;   // entry under scan is the last allocated one
      logic     shift_last;  // this shift moves the last allocated entry
   } ipap_stat_type;

endpackage

// ===== hdl/ipap_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ipap_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ipap_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the address pool: free ring, allocated list, counters, result register.
// Depends on ipap_pkg and ipap_ram.
module ipap_datapath
   import ipap_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [ADDR_W-1:0]   req_address,
   input  mode_type            req_mode,
   input  ipap_cmd_type        cmd,
   output ipap_stat_type       stat,
   output logic [ADDR_W-1:0]   out_address,
   output status_type          out_status,
   output logic [COUNT_W-1:0]  out_free_count,
   output logic [COUNT_W-1:0]  out_alloc_count
);

   // list state
   logic [IDX_W-1:0]   free_head_ff,   free_head_in;
   logic [COUNT_W-1:0] free_total_ff,  free_total_in;
   logic [COUNT_W-1:0] alloc_total_ff, alloc_total_in;
   logic [IDX_W-1:0]   idx_ff,         idx_in;

   // latched request and working result
   logic [ADDR_W-1:0]  addr_ff;
   mode_type           mode_ff;
   logic [ADDR_W-1:0]  res_addr_ff;
   status_type         res_status_ff;

   // result register
   logic [ADDR_W-1:0]  out_addr_ff;
   status_type         out_status_ff;
   logic [COUNT_W-1:0] out_free_ff;
   logic [COUNT_W-1:0] out_alloc_ff;

   // memory ports
   logic               ring_wr_en;
   logic [IDX_W-1:0]   ring_wr_addr;
   logic [ADDR_W-1:0]  ring_rd_data;
   logic               store_wr_en;
   logic [IDX_W-1:0]   store_wr_addr;
   logic [ADDR_W-1:0]  store_wr_data;
   logic [IDX_W-1:0]   store_rd_addr;
   logic [ADDR_W-1:0]  store_rd_data;

   // ring arithmetic
   logic [SUM_W-1:0]   tail_sum;
   logic [IDX_W-1:0]   tail_idx;
   logic [IDX_W-1:0]   head_inc;
   logic [IDX_W-1:0]   head_dec;
   logic [SUM_W-1:0]   pool_sum;
   logic [SUM_W-1:0]   idx_plus1;
   logic [SUM_W-1:0]   idx_plus2;

   // ring positions, wrapping at the pool depth
   always_comb begin
      tail_sum = SUM_W'(free_head_ff) + SUM_W'(free_total_ff);
      if (tail_sum >= SUM_W'(POOL_DEPTH)) begin
         tail_idx = IDX_W'(tail_sum - SUM_W'(POOL_DEPTH));
      end else begin
         tail_idx = IDX_W'(tail_sum);
      end
      head_inc = (free_head_ff == IDX_W'(POOL_DEPTH - 1)) ? '0 : free_head_ff + 1'b1;
      head_dec = (free_head_ff == '0) ? IDX_W'(POOL_DEPTH - 1) : free_head_ff - 1'b1;
      pool_sum  = SUM_W'(free_total_ff) + SUM_W'(alloc_total_ff);
      idx_plus1 = SUM_W'(idx_ff) + SUM_W'(1);
      idx_plus2 = SUM_W'(idx_ff) + SUM_W'(2);
   end

   // status toward the controller
   always_comb begin
      stat.mode        = mode_ff;
      stat.full        = pool_sum >= SUM_W'(POOL_DEPTH);
      stat.free_empty  = free_total_ff == '0;
      stat.alloc_empty = alloc_total_ff == '0;
      stat.match       = store_rd_data == addr_ff;
      stat.scan_last   = idx_plus1 >= SUM_W'(alloc_total_ff);
      stat.shift_last  = idx_plus2 >= SUM_W'(alloc_total_ff);
   end

   // memory port selection
   always_comb begin
      ring_wr_en   = cmd.ring_load | cmd.release_commit;
      ring_wr_addr = cmd.ring_load ? tail_idx : head_dec;

      store_wr_en   = cmd.alloc_commit | cmd.shift_step;
      store_wr_addr = cmd.alloc_commit ? IDX_W'(alloc_total_ff) : idx_ff;
      store_wr_data = cmd.alloc_commit ? ring_rd_data : store_rd_data;

      if (cmd.scan_start) begin
         store_rd_addr = '0;
      end else if (cmd.shift_step) begin
         store_rd_addr = IDX_W'(idx_plus2);
      end else begin
         store_rd_addr = IDX_W'(idx_plus1);
      end
   end

   ipap_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (POOL_DEPTH)
   ) u_free_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (addr_ff),
      .rd_addr (free_head_ff),
      .rd_data (ring_rd_data)
   );

   ipap_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (POOL_DEPTH)
   ) u_alloc_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // next values of the list counters
   always_comb begin
      free_head_in   = free_head_ff;
      free_total_in  = free_total_ff;
      alloc_total_in = alloc_total_ff;
      if (cmd.clear) begin
         free_head_in   = '0;
         free_total_in  = '0;
         alloc_total_in = '0;
      end else if (cmd.ring_load) begin
         free_total_in = free_total_ff + 1'b1;
      end else if (cmd.alloc_commit) begin
         free_head_in   = head_inc;
         free_total_in  = free_total_ff - 1'b1;
         alloc_total_in = alloc_total_ff + 1'b1;
      end else if (cmd.release_commit) begin
         free_head_in   = head_dec;
         free_total_in  = free_total_ff + 1'b1;
         alloc_total_in = alloc_total_ff - 1'b1;
      end
   end

   // scan and shift index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.scan_step || cmd.shift_step) begin
         idx_in = IDX_W'(idx_plus1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff   <= '0;
         free_total_ff  <= '0;
         alloc_total_ff <= '0;
      end else begin
         free_head_ff   <= free_head_in;
         free_total_ff  <= free_total_in;
         alloc_total_ff <= alloc_total_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.capture) begin
         addr_ff       <= req_address;
         mode_ff       <= req_mode;
         res_addr_ff   <= '0;
         res_status_ff <= STATUS_OK;
      end else begin
         if (cmd.alloc_commit) begin
            res_addr_ff <= ring_rd_data;
         end
         if (cmd.set_status) begin
            res_status_ff <= cmd.status;
         end
      end
      if (cmd.load_out) begin
         out_addr_ff   <= res_addr_ff;
         out_status_ff <= res_status_ff;
         out_free_ff   <= free_total_ff;
         out_alloc_ff  <= alloc_total_ff;
      end
   end

   assign out_address     = out_addr_ff;
   assign out_status      = out_status_ff;
   assign out_free_count  = out_free_ff;
   assign out_alloc_count = out_alloc_ff;

   // free plus allocated never exceeds the pool depth
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      pool_sum <= SUM_W'(POOL_DEPTH))
      else $error("free plus allocated exceeds pool depth");

   // a release moves exactly one record from allocated to free
   a_release_moves: assert property (@(posedge clock) disable iff (reset)
      cmd.release_commit |=>
         (free_total_ff == $past(free_total_ff) + 1'b1) &&
         (alloc_total_ff == $past(alloc_total_ff) - 1'b1))
      else $error("release did not move one record");

   // a shift only happens with at least two allocated entries
   a_shift_needs_two: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_step |-> alloc_total_ff >= COUNT_W'(2))
      else $error("shift with fewer than two allocated entries");

endmodule

// ===== hdl/ipap_controller.sv =====
`timescale 1ns / 1ps
// Controller state machine of the address pool: sequences each request beat.
// Depends on ipap_pkg.
module ipap_controller
   import ipap_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  ipap_stat_type stat,
   output ipap_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      slot_free;

   // result register can take a new beat
   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (stat.mode == MODE_ALLOC && !stat.free_empty) begin
               state_in = ST_ALLOC_WR;
            end else if (stat.mode == MODE_RELEASE && !stat.alloc_empty) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_ALLOC_WR: state_in = ST_FINISH;
         ST_SCAN: begin
            if (stat.match && !stat.scan_last) begin
               state_in = ST_SHIFT;
            end else if (stat.match || stat.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            if (stat.shift_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd        = '0;
      cmd.status = STATUS_OK;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_DISPATCH: begin
            case (stat.mode)
               MODE_LOAD: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STATUS_FULL;
                  end else begin
                     cmd.ring_load = 1'b1;
                  end
               end
               MODE_ALLOC: begin
                  if (stat.free_empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STATUS_EMPTY;
                  end
               end
               MODE_RELEASE: begin
                  cmd.set_status = 1'b1;
                  cmd.status     = STATUS_NOT_ALLOC;
                  cmd.scan_start = !stat.alloc_empty;
               end
               MODE_CLEAR: cmd.clear = 1'b1;
               default: cmd.clear = 1'b1;
            endcase
         end
         ST_ALLOC_WR: cmd.alloc_commit = 1'b1;
         ST_SCAN: begin
            if (stat.match) begin
               cmd.set_status     = 1'b1;
               cmd.status         = STATUS_OK;
               cmd.release_commit = stat.scan_last;
            end else begin
               cmd.scan_step = !stat.scan_last;
            end
         end
         ST_SHIFT: begin
            cmd.shift_step     = 1'b1;
            cmd.release_commit = stat.shift_last;
         end
         ST_FINISH: cmd.load_out = slot_free;
         default: ;
      endcase
   end

   // result valid flag
   assign rsp_tvalid_in = cmd.load_out || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   // an accepted beat always goes to dispatch next
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_DISPATCH)
      else $error("accepted beat not dispatched");

   // a result is loaded only into a free or draining result register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result register overwritten");

endmodule

// ===== hdl/ipv4_address_pool_allocator.sv =====
`timescale 1ns / 1ps
// Each request beat passes dispatch and finish; allocate adds an allocate-write step, and
// a release on a non-empty list adds a scan and a shift of any entries after the match.
// One request at a time: the next beat is taken once the result is in the output
// register; the release search, one allocated entry per RAM read, sets the worst case.
// Reset (synchronous, active high) empties both lists; list RAMs are not cleared.
module ipv4_address_pool_allocator
   import ipap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] address
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // [31:0] result_address, [33:32] status,
                                    // [42:34] free_count, [51:43] allocated_count,
                                    // [55:52] zero
);

   ipap_cmd_type       cmd;
   ipap_stat_type      stat;
   logic [ADDR_W-1:0]  out_address;
   status_type         out_status;
   logic [COUNT_W-1:0] out_free_count;
   logic [COUNT_W-1:0] out_alloc_count;

   ipap_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ipap_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_address     (req_tdata),
      .req_mode        (mode_type'(req_tuser)),
      .cmd             (cmd),
      .stat            (stat),
      .out_address     (out_address),
      .out_status      (out_status),
      .out_free_count  (out_free_count),
      .out_alloc_count (out_alloc_count)
   );

   // result beat packing
   assign rsp_tdata = {4'b0000, out_alloc_count, out_free_count, out_status, out_address};

endmodule
